// ----- hw/rtl/lzwd_pkg.sv -----
// Shared constants, dictionary entry type and the control/status bundles
// of the fixed-width LZW decoder. No dependencies.
`default_nettype none

package lzwd_pkg;

  // Code space
  localparam int CODE_BITS   = 12;
  localparam int TABLE_DEPTH = 1 << CODE_BITS;
  localparam int TOP_CODE    = TABLE_DEPTH - 1;
  localparam int NF_W        = CODE_BITS + 1;
  localparam int END_CODE    = 256;
  localparam int FIRST_FREE  = 257;
  localparam int LIT_MAX     = 255;

  // Reversal stack
  localparam int STACK_DEPTH = 1024;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = STACK_AW + 1;

  // Result item packing
  localparam int BYTES_PER_ITEM = 16;
  localparam int LANE_AW        = $clog2(BYTES_PER_ITEM);
  localparam int CNT_W          = LANE_AW + 1;
  localparam int HALF_W         = 64;

  typedef struct packed {
    logic [CODE_BITS-1:0] parent;
    logic [7:0]           chr;
  } dict_entry_t;

  localparam int ENTRY_W = $bits(dict_entry_t);

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic start_end;
    logic start_first;
    logic start_undef;
    logic start_known;
    logic set_trunc;
    logic push_lit;
    logic link_rd;
    logic push_link;
    logic update;
    logic gather_init;
    logic gather;
    logic load;
    logic load_end;
  } lzwd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_end;
    logic started;
    logic code_undef;
    logic depth_full;
    logic cur_terminal;
    logic gather_done;
    logic pos_zero;
    logic out_free;
  } lzwd_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lzw_fixed_width_decoder.sv -----
// Top level of the fixed-width LZW decoder: controller plus datapath.
// Depends on lzwd_pkg, lzwd_ctrl, lzwd_dp (and lzwd_ram through it).
`default_nettype none

// Decodes one 12-bit LZW code per input transfer into result items of up
// to 16 bytes each, in string order. Codes 0-255 are literals, 256 ends the
// stream (one empty item with stream_end set, dictionary restarts), higher
// codes index a 4096-entry dictionary that stops growing once full. One
// code is worked on at a time. Decoding walks the dictionary link by link
// (the dictionary RAM has a registered read, and the next link address
// comes from that read), pushes the final literal and updates the table,
// then reads the 1024-byte reversal stack back out byte by byte, draining
// the stack read and loading the result register for each result item.
// Strings longer than 1024 bytes keep their tail and flag overflow. The
// result register lets the next code be taken while the last item still
// waits for out_ready.
module lzw_fixed_width_decoder import lzwd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CODE_BITS-1:0] code,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [HALF_W-1:0]         bytes_low,
  output logic [HALF_W-1:0]         bytes_high,
  output logic [CNT_W-1:0]          byte_count,
  output logic                      last_of_code,
  output logic                      stream_end,
  output logic                      overflow
);

  lzwd_cmd_t cmd;
  lzwd_sts_t sts;

  lzwd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  lzwd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .code        (code),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bytes_low   (bytes_low),
    .bytes_high  (bytes_high),
    .byte_count  (byte_count),
    .last_of_code(last_of_code),
    .stream_end  (stream_end),
    .overflow    (overflow)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/lzwd_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lzwd_ctrl.sv -----
// Sequencing state machine of the LZW decoder: decode, chain walk,
// dictionary update, output gathering. Depends on lzwd_pkg.
`default_nettype none

module lzwd_ctrl import lzwd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire lzwd_sts_t sts,
  output lzwd_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WALK_CHK,
    S_WALK_LINK,
    S_UPDATE,
    S_PREP,
    S_GATHER,
    S_LOAD,
    S_LOAD_END
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.is_end) begin
          cmd.start_end = 1'b1;
          state_next    = S_LOAD_END;
        end else if (!sts.started) begin
          cmd.start_first = 1'b1;
          state_next      = S_PREP;
        end else if (sts.code_undef) begin
          cmd.start_undef = 1'b1;
          state_next      = S_WALK_CHK;
        end else begin
          cmd.start_known = 1'b1;
          state_next      = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        priority if (sts.depth_full) begin
          cmd.set_trunc = 1'b1;
          state_next    = S_UPDATE;
        end else if (sts.cur_terminal) begin
          cmd.push_lit = 1'b1;
          state_next   = S_UPDATE;
        end else begin
          cmd.link_rd = 1'b1;
          state_next  = S_WALK_LINK;
        end
      end
      S_WALK_LINK: begin
        cmd.push_link = 1'b1;
        state_next    = S_WALK_CHK;
      end
      S_UPDATE: begin
        cmd.update      = 1'b1;
        cmd.gather_init = 1'b1;
        state_next      = S_GATHER;
      end
      S_PREP: begin
        cmd.gather_init = 1'b1;
        state_next      = S_GATHER;
      end
      S_GATHER: begin
        cmd.gather = 1'b1;
        if (sts.gather_done) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = sts.pos_zero ? S_IDLE : S_GATHER;
        end
      end
      S_LOAD_END: begin
        if (sts.out_free) begin
          cmd.load_end = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lzwd_dp.sv -----
// Datapath of the LZW decoder: dictionary and stack RAMs, chain pointer,
// stream state, byte gathering and the output register. Depends on
// lzwd_pkg and lzwd_ram.
`default_nettype none

module lzwd_dp import lzwd_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [CODE_BITS-1:0]   code,
  input  wire lzwd_cmd_t              cmd,
  output lzwd_sts_t                   sts,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [HALF_W-1:0]           bytes_low,
  output logic [HALF_W-1:0]           bytes_high,
  output logic [CNT_W-1:0]            byte_count,
  output logic                        last_of_code,
  output logic                        stream_end,
  output logic                        overflow
);

  // Stream and walk state
  logic [CODE_BITS-1:0] code_r;
  logic [CODE_BITS-1:0] cur;
  logic [CODE_BITS-1:0] prev_code;
  logic [NF_W-1:0]      next_free;
  logic [7:0]           first_byte;
  logic [7:0]           last_byte;
  logic                 started;
  logic                 trunc;
  logic [DEPTH_W-1:0]   depth;

  // Gather state
  logic [DEPTH_W-1:0]            pos;
  logic [DEPTH_W-1:0]            pos_dec;
  logic [CNT_W-1:0]              cnt_iss;
  logic [CNT_W-1:0]              cnt_rcv;
  logic                          pending;
  logic                          issue;
  logic [2*HALF_W-1:0]           gbuf;

  // RAM ports
  dict_entry_t          dict_rdata;
  dict_entry_t          dict_wdata;
  logic                 dict_we;
  logic                 stk_we;
  logic [STACK_AW-1:0]  stk_waddr;
  logic [7:0]           stk_wdata;
  logic [7:0]           stk_rdata;

  logic table_open;

  assign table_open = (next_free <= NF_W'(TOP_CODE));
  assign pos_dec    = pos - 1'b1;
  assign issue      = cmd.gather && (cnt_iss < CNT_W'(BYTES_PER_ITEM)) && (pos != '0);

  // Status
  always_comb begin
    sts.is_end       = (code_r == CODE_BITS'(END_CODE));
    sts.started      = started;
    sts.code_undef   = ({1'b0, code_r} >= next_free);
    sts.depth_full   = (depth >= DEPTH_W'(STACK_DEPTH));
    sts.cur_terminal = (cur <= CODE_BITS'(LIT_MAX)) || ({1'b0, cur} >= next_free);
    sts.gather_done  = !pending && ((cnt_iss == CNT_W'(BYTES_PER_ITEM)) || (pos == '0));
    sts.pos_zero     = (pos == '0);
    sts.out_free     = !out_valid || out_ready;
  end

  // Stack write select
  always_comb begin
    stk_we    = cmd.start_first || cmd.start_undef || cmd.push_lit || cmd.push_link;
    stk_waddr = (cmd.start_first || cmd.start_undef) ? '0 : depth[STACK_AW-1:0];
    priority if (cmd.start_first) begin
      stk_wdata = code_r[7:0];
    end else if (cmd.start_undef) begin
      stk_wdata = first_byte;
    end else if (cmd.push_lit) begin
      stk_wdata = cur[7:0];
    end else begin
      stk_wdata = dict_rdata.chr;
    end
  end

  // New dictionary entry: previous code plus first byte of this string
  assign dict_we           = cmd.update && table_open;
  assign dict_wdata.parent = prev_code;
  assign dict_wdata.chr    = last_byte;

  lzwd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_dict (
    .clk  (clk),
    .we   (dict_we),
    .waddr(next_free[CODE_BITS-1:0]),
    .wdata(dict_wdata),
    .rd_en(cmd.link_rd),
    .raddr(cur),
    .rdata(dict_rdata)
  );

  lzwd_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .rd_en(issue),
    .raddr(pos_dec[STACK_AW-1:0]),
    .rdata(stk_rdata)
  );

  // Stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free  <= NF_W'(FIRST_FREE);
      prev_code  <= '0;
      first_byte <= '0;
      started    <= 1'b0;
    end else begin
      if (cmd.start_end) begin
        next_free <= NF_W'(FIRST_FREE);
        started   <= 1'b0;
      end
      if (cmd.start_first) begin
        first_byte <= code_r[7:0];
        prev_code  <= {{(CODE_BITS-8){1'b0}}, code_r[7:0]};
        started    <= 1'b1;
      end
      if (cmd.update) begin
        first_byte <= last_byte;
        prev_code  <= code_r;
        if (table_open) begin
          next_free <= next_free + 1'b1;
        end
      end
    end
  end

  // Code capture and chain walk
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code_r <= code;
    end
    if (cmd.start_first) begin
      depth <= DEPTH_W'(1);
      trunc <= 1'b0;
    end
    if (cmd.start_undef) begin
      depth     <= DEPTH_W'(1);
      cur       <= prev_code;
      trunc     <= 1'b0;
      last_byte <= first_byte;
    end
    if (cmd.start_known) begin
      depth <= '0;
      cur   <= code_r;
      trunc <= 1'b0;
    end
    if (cmd.set_trunc) begin
      trunc <= 1'b1;
    end
    if (cmd.push_lit) begin
      depth     <= depth + 1'b1;
      last_byte <= cur[7:0];
    end
    if (cmd.push_link) begin
      depth     <= depth + 1'b1;
      last_byte <= dict_rdata.chr;
      cur       <= dict_rdata.parent;
    end
  end

  // Gather: one stack read per cycle until the item is full, newest entry first
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      pos     <= '0;
      cnt_iss <= '0;
      cnt_rcv <= '0;
    end else begin
      pending <= issue;
      if (cmd.gather_init || cmd.load) begin
        cnt_iss <= '0;
        cnt_rcv <= '0;
      end else begin
        if (issue) begin
          cnt_iss <= cnt_iss + 1'b1;
        end
        if (pending) begin
          cnt_rcv <= cnt_rcv + 1'b1;
        end
      end
      if (cmd.gather_init) begin
        pos <= depth;
      end else if (issue) begin
        pos <= pos_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gather_init || cmd.load) begin
      gbuf <= '0;
    end else if (pending) begin
      gbuf[{cnt_rcv[LANE_AW-1:0], 3'b000} +: 8] <= stk_rdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load || cmd.load_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bytes_low    <= gbuf[HALF_W-1:0];
      bytes_high   <= gbuf[2*HALF_W-1:HALF_W];
      byte_count   <= cnt_rcv;
      last_of_code <= (pos == '0);
      stream_end   <= 1'b0;
      overflow     <= trunc;
    end else if (cmd.load_end) begin
      bytes_low    <= '0;
      bytes_high   <= '0;
      byte_count   <= '0;
      last_of_code <= 1'b1;
      stream_end   <= 1'b1;
      overflow     <= 1'b0;
    end
  end

  // Checks
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_lit || cmd.push_link) |-> !sts.depth_full)
    else $error("stack push beyond its depth");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= NF_W'(TABLE_DEPTH))
    else $error("next free code past the table");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load || cmd.load_end) |-> (!out_valid || out_ready))
    else $error("output register overwritten before transfer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (cnt_rcv != '0) && (cnt_rcv <= CNT_W'(BYTES_PER_ITEM)))
    else $error("result item byte count out of range");

  a_no_read_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !pending)
    else $error("result loaded with a stack read in flight");

endmodule

`default_nettype wire
